FILE: hdl/gsm7p_pkg.sv
package gsm7p_pkg;

    localparam int MaxOctetsDefault  = 160;
    localparam int QueueDepthDefault = 2;

    localparam int InDataW  = 8;
    localparam int OutDataW = 24;

    localparam logic [6:0] EscSeptet = 7'h1B;

    typedef struct packed {
        logic       ext;
        logic [6:0] code;
        logic       last;
    } t_sym;

    typedef struct packed {
        logic       truncated;
        logic [7:0] septet_total;
        logic       final_octet;
        logic [7:0] octet;
    } t_beat;

    // Extension characters become an escape septet and an extension code;
    // default-alphabet characters become their table index.
    function automatic t_sym f_classify(input logic [6:0] c, input logic last);
        t_sym r;
        r.ext  = 1'b1;
        r.code = c;
        r.last = last;
        unique case (c)
            7'h0C: r.code = 7'h0A;
            7'h5B: r.code = 7'h3C;
            7'h5C: r.code = 7'h2F;
            7'h5D: r.code = 7'h3E;
            7'h5E: r.code = 7'h14;
            7'h7B: r.code = 7'h28;
            7'h7C: r.code = 7'h40;
            7'h7D: r.code = 7'h29;
            7'h7E: r.code = 7'h3D;
            default: begin
                r.ext = 1'b0;
                unique case (c)
                    7'h40:   r.code = 7'd0;
                    7'h24:   r.code = 7'd2;
                    7'h0A:   r.code = 7'd10;
                    7'h0D:   r.code = 7'd13;
                    7'h5F:   r.code = 7'd17;
                    7'h1B:   r.code = 7'd27;
                    default: r.code = c;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/gsm7p_front.sv
module gsm7p_front
    import gsm7p_pkg::*;
(
    input  logic               i_tvalid,
    input  logic [InDataW-1:0] i_tdata,
    input  logic               i_tlast,
    input  logic               i_full,
    output logic               o_tready,
    output logic               o_push,
    output t_sym               o_sym
);

    assign o_tready = !i_full;
    assign o_push   = i_tvalid && !i_full;
    assign o_sym    = f_classify(i_tdata[6:0], i_tlast);

endmodule

FILE: hdl/gsm7p_fifo.sv
module gsm7p_fifo
    import gsm7p_pkg::*;
#(
    parameter int DEPTH = QueueDepthDefault
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_sym i_sym,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_sym o_sym
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

    t_sym            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [CntW-1:0] n_count;

    assign o_full  = r_count == CntW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_sym   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_sym;
        end
    end

endmodule

FILE: hdl/gsm7p_back.sv
module gsm7p_back
    import gsm7p_pkg::*;
#(
    parameter int MAX_OCTETS = MaxOctetsDefault
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sym i_sym,
    output logic o_pop,
    input  logic i_tready,
    output logic o_tvalid,
    output t_beat o_beat
);

    localparam logic [7:0] MaxOct = 8'(MAX_OCTETS);

    logic [6:0] r_res_bits;
    logic [2:0] r_res_cnt;
    logic [7:0] r_sent;
    logic [7:0] r_septs;
    logic       r_over;
    logic       r_char_emit;
    logic       r_esc_done;
    logic       r_flush;
    logic       r_out_valid;
    t_beat      r_out;

    logic [6:0] n_res_bits;
    logic [2:0] n_res_cnt;
    logic [7:0] n_sent;
    logic [7:0] n_septs;
    logic       n_over;
    logic       n_char_emit;
    logic       n_esc_done;
    logic       n_flush;
    logic       n_out_valid;
    t_beat      n_out;

    logic        can_go;
    logic        step;
    logic [6:0]  septet;
    logic        second;
    logic [13:0] acc;
    logic        full;
    logic        room;
    logic        emit;
    logic        drop;
    logic [6:0]  nb;
    logic [2:0]  nc;
    logic [7:0]  ns;
    logic [7:0]  nsep;
    logic [7:0]  nsep2;
    logic        nover;
    logic        fl_emit;
    logic        need_flush;

    assign can_go = !r_out_valid || i_tready;
    assign step   = i_valid && can_go;

    always_comb begin
        septet     = (i_sym.ext && !r_esc_done) ? EscSeptet : i_sym.code;
        second     = !i_sym.ext || r_esc_done;
        acc        = {7'b0, r_res_bits} | ({7'b0, septet} << r_res_cnt);
        full       = r_res_cnt != 3'd0;
        room       = r_sent < MaxOct;
        emit       = full && room;
        drop       = full && !room;
        nb         = full ? {1'b0, acc[13:8]} : acc[6:0];
        nc         = full ? r_res_cnt - 3'd1 : 3'd7;
        ns         = r_sent + {7'b0, emit};
        nsep       = (r_septs == 8'hFF) ? r_septs : r_septs + 8'd1;
        nsep2      = (nsep == 8'hFF) ? nsep : nsep + 8'd1;
        nover      = r_over || drop;
        fl_emit    = (nc != 3'd0) && (ns < MaxOct);
        need_flush = fl_emit || (!emit && !r_char_emit);
    end

    always_comb begin
        n_res_bits  = r_res_bits;
        n_res_cnt   = r_res_cnt;
        n_sent      = r_sent;
        n_septs     = r_septs;
        n_over      = r_over;
        n_char_emit = r_char_emit;
        n_esc_done  = r_esc_done;
        n_flush     = r_flush;
        n_out_valid = r_out_valid && !i_tready;
        n_out       = r_out;
        o_pop       = 1'b0;
        if (step && r_flush) begin
            n_out_valid        = 1'b1;
            n_out.octet        = room && full ? {1'b0, r_res_bits} : 8'd0;
            n_out.final_octet  = 1'b1;
            n_out.septet_total = r_septs;
            n_out.truncated    = r_over || drop;
            n_res_bits  = '0;
            n_res_cnt   = '0;
            n_sent      = '0;
            n_septs     = '0;
            n_over      = 1'b0;
            n_char_emit = 1'b0;
            n_esc_done  = 1'b0;
            n_flush     = 1'b0;
            o_pop       = 1'b1;
        end else if (step) begin
            if (emit) begin
                n_out_valid        = 1'b1;
                n_out.octet        = acc[7:0];
                n_out.final_octet  = 1'b0;
                n_out.septet_total = 8'd0;
                n_out.truncated    = 1'b0;
            end
            n_res_bits = nb;
            n_res_cnt  = nc;
            n_sent     = ns;
            n_septs    = nsep;
            n_over     = nover;
            if (second && i_sym.last) begin
                if (need_flush) begin
                    n_flush = 1'b1;
                end else begin
                    n_out.final_octet  = 1'b1;
                    n_out.septet_total = nsep;
                    n_out.truncated    = nover || (nc != 3'd0);
                    n_res_bits  = '0;
                    n_res_cnt   = '0;
                    n_sent      = '0;
                    n_septs     = '0;
                    n_over      = 1'b0;
                    n_char_emit = 1'b0;
                    n_esc_done  = 1'b0;
                    o_pop       = 1'b1;
                end
            end else if (second) begin
                n_char_emit = 1'b0;
                n_esc_done  = 1'b0;
                o_pop       = 1'b1;
            end else if (i_sym.last && emit && ns == MaxOct) begin
                // The escape septet fills the last allowed octet, so the extension
                // code and any partial octet are dropped and this beat ends the message.
                n_out.final_octet  = 1'b1;
                n_out.septet_total = nsep2;
                n_out.truncated    = 1'b1;
                n_res_bits  = '0;
                n_res_cnt   = '0;
                n_sent      = '0;
                n_septs     = '0;
                n_over      = 1'b0;
                n_char_emit = 1'b0;
                n_esc_done  = 1'b0;
                o_pop       = 1'b1;
            end else begin
                n_char_emit = r_char_emit || emit;
                n_esc_done  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_bits  <= '0;
            r_res_cnt   <= '0;
            r_sent      <= '0;
            r_septs     <= '0;
            r_over      <= 1'b0;
            r_char_emit <= 1'b0;
            r_esc_done  <= 1'b0;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_res_bits  <= n_res_bits;
            r_res_cnt   <= n_res_cnt;
            r_sent      <= n_sent;
            r_septs     <= n_septs;
            r_over      <= n_over;
            r_char_emit <= n_char_emit;
            r_esc_done  <= n_esc_done;
            r_flush     <= n_flush;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_tvalid = r_out_valid;
    assign o_beat   = r_out;

endmodule

FILE: hdl/gsm7_text_encoder_packer_top.sv
// GSM 7-bit text encoder and septet packer.
// The slave stream takes one ASCII character per beat with tlast on the last
// character of a message. The master stream gives one packed octet per beat,
// septets packed least significant bit first, with tlast on the last octet.
// On that last beat tdata also carries the saturating septet count and the
// truncation flag; both are zero on every other beat. A message whose octets
// were all dropped past MAX_OCTETS still ends with one zero octet beat.
// A classifier front end writes each character into a short queue, and the
// packer behind it works one septet per cycle into an output register
// while that register is empty or being read and no flush is pending.
// It packs a plain character as one septet and an extension character as
// the escape septet and then its code; the last character needs a further
// flush step when a partial octet or the zero octet beat is flushed.
// A character reaches the packer from the queue head once earlier septets
// are done, and each of its octets is then valid from the output register.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and tready falls once QUEUE_DEPTH characters are waiting.
// Reset clears the queue, the output valid flag and all packing state.
module gsm7_text_encoder_packer_top
    import gsm7p_pkg::*;
#(
    parameter int MAX_OCTETS  = MaxOctetsDefault,
    parameter int QUEUE_DEPTH = QueueDepthDefault
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [InDataW-1:0]  i_s_axis_tdata,  // [6:0] character, [7] zero
    input  logic                i_s_axis_tlast,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [OutDataW-1:0] o_m_axis_tdata,  // [7:0] octet, [15:8] septet_total,
                                                 // [16] truncated, [23:17] zero
    output logic                o_m_axis_tlast
);

    logic  w_full;
    logic  w_push;
    t_sym  w_push_sym;
    logic  w_head_valid;
    t_sym  w_head_sym;
    logic  w_pop;
    t_beat w_beat;

    gsm7p_front u_front (
        .i_tvalid (i_s_axis_tvalid),
        .i_tdata  (i_s_axis_tdata),
        .i_tlast  (i_s_axis_tlast),
        .i_full   (w_full),
        .o_tready (o_s_axis_tready),
        .o_push   (w_push),
        .o_sym    (w_push_sym)
    );

    gsm7p_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_sym   (w_push_sym),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_sym   (w_head_sym)
    );

    gsm7p_back #(
        .MAX_OCTETS (MAX_OCTETS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_head_valid),
        .i_sym    (w_head_sym),
        .o_pop    (w_pop),
        .i_tready (i_m_axis_tready),
        .o_tvalid (o_m_axis_tvalid),
        .o_beat   (w_beat)
    );

    assign o_m_axis_tdata = {7'b0, w_beat.truncated, w_beat.septet_total, w_beat.octet};
    assign o_m_axis_tlast = w_beat.final_octet;

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("character written into a full queue");

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid)
        else $error("queue popped while empty");

    a_status_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> (o_m_axis_tdata[16:8] == 9'd0))
        else $error("status fields set on a beat that is not the last");

    a_beat_pops_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !$past(o_m_axis_tvalid) && o_m_axis_tlast) |-> $past(w_pop))
        else $error("last beat produced without retiring its character");

endmodule
